@@ sv/pairwise_gravity_acceleration_top_assert.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef PAIRWISE_GRAVITY_ACCELERATION_TOP_ASSERT_SVH
`define PAIRWISE_GRAVITY_ACCELERATION_TOP_ASSERT_SVH

// same-cycle implication
`define PGA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PGA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/pga_pkg.sv @@
// types, constants and helper functions for the gravity acceleration block
// no dependencies
`default_nettype none
package pga_pkg;

   localparam int MAX_BODIES_DEF = 16;
   localparam int REQ_W          = 256;
   localparam int RSP_W          = 200;
   localparam int IDX_OUT_W      = 6;

   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [63:0] mass;
      logic [63:0] px;
      logic [63:0] py;
      logic [63:0] pz;
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] az;
      logic        sat;
   } body_type;

   typedef struct packed {
      logic            skip;
      logic [2:0]      neg;
      logic [2:0][63:0] ti;
      logic [2:0]      ci;
      logic [2:0][63:0] tj;
      logic [2:0]      cj;
   } pair_result_type;

   typedef enum logic [2:0] {
      T_LOAD, T_CAPTURE, T_WALK, T_PAIR, T_OUT
   } top_state_type;

   typedef enum logic [3:0] {
      P_IDLE, P_DIFF, P_NORM, P_SQ, P_SQRT, P_R3, P_DIV,
      P_TH, P_PJ, P_PI, P_SCALE, P_DONE
   } pair_state_type;

   // saturating add or subtract of a magnitude, overflow flag on top
   function automatic logic [64:0] sat_add(input logic [63:0] acc, input logic neg,
                                           input logic [63:0] mag);
      logic [64:0] s;
      if (neg) s = {acc[63], acc} - {1'b0, mag};
      else     s = {acc[63], acc} + {1'b0, mag};
      if (s[64] != s[63]) return {1'b1, (neg ? NEG_MIN : POS_MAX)};
      return {1'b0, s[63:0]};
   endfunction

endpackage
`default_nettype wire

@@ sv/pairwise_gravity_acceleration_top.sv @@
// load: one body per cycle; a pair runs a start, 64 root steps, 128 divide steps and 13
// products on the shared 32x32 multiplier
// after its last body a set of n bodies is computed, then n result transfers follow,
// one per cycle while accepted
// throughput is one set at a time; no new body is taken until the last result transfers
// reset (synchronous, active high) empties the set and returns to loading
`default_nettype none
module pairwise_gravity_acceleration_top import pga_pkg::*; #(
   parameter int MAX_BODIES = MAX_BODIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // body input
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // body_mass, pos_x, pos_y, pos_z
   input  logic             req_tlast,  // last_body
   // acceleration output
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // body_index, acc_x, acc_y, acc_z, zero pad
   output logic             rsp_tuser,  // saturated
   output logic             rsp_tlast   // last_result
);
   localparam int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int CW = $clog2(MAX_BODIES + 1);

   top_state_type   state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in, n_ff, n_in;
   logic [IW-1:0]   head_idx_ff, head_idx_in, pi_ff, pi_in;
   body_type        piv_ff, piv_in;

   body_type        cell_q [MAX_BODIES];
   body_type        head, head_mod, load_data;
   logic            rotate, req_xfer, rsp_xfer, head_last, pair_start, pair_done;
   pair_result_type pres;
   logic [2:0][63:0] ha, pa;
   logic [64:0]     sj, si;
   logic            sat_h, sat_p;

   assign head      = cell_q[0];
   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_xfer  = rsp_tvalid && rsp_tready;
   // head holds the final body of the set
   assign head_last = ({1'b0, head_idx_ff} == (IW + 1)'(n_ff - CW'(1)));

   // new body enters with cleared accumulators
   always_comb begin
      load_data      = '0;
      load_data.mass = req_tdata[63:0];
      load_data.px   = req_tdata[127:64];
      load_data.py   = req_tdata[191:128];
      load_data.pz   = req_tdata[255:192];
   end

   // ring of body cells; cell 0 is the head, the last live cell takes the head back
   for (genvar k = 0; k < MAX_BODIES; k++) begin : g_cell
      body_type nb;
      if (k == MAX_BODIES - 1) begin : g_end
         assign nb = head_mod;
      end else begin : g_mid
         assign nb = (CW'(k) == n_ff - CW'(1)) ? head_mod : cell_q[k + 1];
      end
      pga_cell u_cell (
         .clock      (clock),
         .load_en    (req_xfer && count_ff == CW'(k)),
         .load_data  (load_data),
         .shift_en   (rotate && CW'(k) < n_ff),
         .shift_data (nb),
         .q          (cell_q[k])
      );
   end

   pga_pair u_pair (
      .clock (clock), .reset (reset), .start (pair_start),
      .pivot (piv_ff), .head (head), .done (pair_done), .result (pres)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_LOAD:    if (req_xfer && req_tlast) state_in = T_CAPTURE;
         T_CAPTURE: state_in = T_WALK;
         T_WALK: begin
            if (head_idx_ff == pi_ff) begin
               state_in = ({1'b0, pi_ff} == (IW + 1)'(n_ff - CW'(1))) ? T_OUT : T_CAPTURE;
            end else if (head_idx_ff > pi_ff) begin
               state_in = T_PAIR;
            end
         end
         T_PAIR:    if (pair_done) state_in = T_WALK;
         T_OUT:     if (rsp_xfer && head_last) state_in = T_LOAD;
         default:   state_in = T_LOAD;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = (state_ff == T_LOAD);
      rsp_tvalid = (state_ff == T_OUT);
      pair_start = 1'b0;
      rotate     = 1'b0;
      case (state_ff)
         T_CAPTURE: rotate = 1'b1;
         T_WALK: begin
            pair_start = (head_idx_ff > pi_ff);
            rotate     = !(head_idx_ff > pi_ff);
         end
         T_PAIR:    rotate = pair_done;
         T_OUT:     rotate = rsp_xfer;
         default:   rotate = 1'b0;
      endcase
   end

   // accumulate pair terms into the head body and the pivot body
   always_comb begin
      ha = {head.az, head.ay, head.ax};
      pa = {piv_ff.az, piv_ff.ay, piv_ff.ax};
      sat_h = head.sat;
      sat_p = piv_ff.sat;
      sj = '0; si = '0;
      for (int c = 0; c < 3; c++) begin
         sj = sat_add(ha[c], pres.neg[c], pres.tj[c]);
         si = sat_add(pa[c], !pres.neg[c], pres.ti[c]);
         ha[c] = sj[63:0];
         pa[c] = si[63:0];
         sat_h = sat_h | sj[64] | pres.cj[c];
         sat_p = sat_p | si[64] | pres.ci[c];
      end

      head_mod = head;
      piv_in   = piv_ff;
      if (state_ff == T_CAPTURE) begin
         piv_in = head;
      end else if (state_ff == T_WALK && head_idx_ff == pi_ff) begin
         // pivot sums go back into its own cell
         head_mod = piv_ff;
      end else if (state_ff == T_PAIR && pair_done && !pres.skip) begin
         head_mod.ax  = ha[0]; head_mod.ay = ha[1]; head_mod.az = ha[2];
         head_mod.sat = sat_h;
         piv_in.ax    = pa[0]; piv_in.ay = pa[1]; piv_in.az = pa[2];
         piv_in.sat   = sat_p;
      end
   end

   // counters
   always_comb begin
      count_in    = count_ff;
      n_in        = n_ff;
      head_idx_in = head_idx_ff;
      pi_in       = pi_ff;
      if (req_xfer) begin
         // bodies beyond capacity are dropped
         if (count_ff < CW'(MAX_BODIES)) count_in = count_ff + CW'(1);
         if (req_tlast) begin
            n_in        = count_in;
            head_idx_in = '0;
            pi_in       = '0;
         end
      end
      if (rotate) begin
         head_idx_in = head_last ? '0 : head_idx_ff + IW'(1);
      end
      if (state_ff == T_WALK && head_idx_ff == pi_ff && state_in == T_CAPTURE) begin
         pi_in = pi_ff + IW'(1);
      end
      if (state_ff == T_OUT && rsp_xfer && head_last) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= T_LOAD;
         count_ff    <= '0;
         n_ff        <= '0;
         head_idx_ff <= '0;
         pi_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         n_ff        <= n_in;
         head_idx_ff <= head_idx_in;
         pi_ff       <= pi_in;
      end
      piv_ff <= piv_in;
   end

   // results leave from the head cell in load order
   assign rsp_tdata = {2'b00, head.az, head.ay, head.ax, IDX_OUT_W'(head_idx_ff)};
   assign rsp_tuser = head.sat;
   assign rsp_tlast = head_last;
endmodule
`default_nettype wire

@@ sv/pga_cell.sv @@
// one body cell of the rotating ring: mass, position, accumulators
// depends on pga_pkg
`default_nettype none
module pga_cell import pga_pkg::*; (
   input  logic     clock,
   input  logic     load_en,
   input  body_type load_data,
   input  logic     shift_en,
   input  body_type shift_data,
   output body_type q
);
   body_type cell_ff, cell_in;

   always_comb begin
      cell_in = cell_ff;
      if (load_en) begin
         cell_in = load_data;
      end else if (shift_en) begin
         cell_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign q = cell_ff;
endmodule
`default_nettype wire

@@ sv/pga_mul.sv @@
// 64x64 unsigned multiplier, one 32x32 partial product per cycle
// depends on pga_pkg
`default_nettype none
module pga_mul import pga_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] p
);
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   k_ff, k_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  pa, pb;
   logic [63:0]  part;
   logic [127:0] part_sh;

   always_comb begin
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff; k_in = k_ff;
      busy_in = busy_ff; done_in = 1'b0;
      pa = k_ff[1] ? a_ff[63:32] : a_ff[31:0];
      pb = k_ff[0] ? b_ff[63:32] : b_ff[31:0];
      part = pa * pb;
      case (k_ff)
         2'd0:    part_sh = {64'd0, part};
         2'd3:    part_sh = {part, 64'd0};
         default: part_sh = {32'd0, part, 32'd0};
      endcase
      if (busy_ff) begin
         acc_in = acc_ff + part_sh;
         k_in   = k_ff + 2'd1;
         if (k_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         a_in = a; b_in = b; acc_in = '0; k_in = '0; busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         k_ff    <= k_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign p    = acc_ff;
endmodule
`default_nettype wire

@@ sv/pga_pair.sv @@
// pair interaction engine: normalize, square, root, divide, scale
// depends on pga_pkg and pga_mul
`default_nettype none
module pga_pair import pga_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  body_type        pivot,
   input  body_type        head,
   output logic            done,
   output pair_result_type result
);
   localparam logic [6:0] SQRT_LAST = 7'd63;
   localparam logic [6:0] DIV_TOP   = 7'd127;
   localparam logic [6:0] DIV_ONE   = 7'd118;

   pair_state_type   state_ff, state_in;
   logic [2:0][63:0] mag_ff, mag_in, dn_ff, dn_in;
   logic [2:0]       neg_ff, neg_in;
   logic [6:0]       e_ff, e_in;
   logic [127:0]     r2_ff, r2_in, sx_ff, sx_in, pj_ff, pj_in, pi_ff, pi_in;
   logic [63:0]      root_ff, root_in, r3h_ff, r3h_in, dr_ff, dr_in, q_ff, q_in;
   logic [63:0]      th_ff, th_in;
   logic [66:0]      rem_ff, rem_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic [1:0]       c_ff, c_in;
   logic             busy_ff, busy_in;
   pair_result_type  res_ff, res_in;

   logic         mul_start, mul_done;
   logic [63:0]  mul_a, mul_b;
   logic [127:0] mul_p;

   logic [63:0]  mx, a, b, remv;
   logic [6:0]   bl, e_n;
   logic [66:0]  rem_t, trial;
   logic signed [8:0] sh;
   logic [64:0]  sj, si;
   logic         carry;

   function automatic logic [6:0] bitlen(input logic [63:0] x);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) n = 7'(i + 1);
      end
      return n;
   endfunction

   function automatic logic [64:0] scale_term(input logic [127:0] p,
                                              input logic signed [8:0] s);
      logic [127:0] v;
      logic [6:0]   amt;
      logic         clip;
      logic [63:0]  t;
      amt = '0;
      if (s > 0) begin
         amt  = s[6:0];
         v    = p >> (7'd63 - amt);
         clip = |v;
         t    = p[63:0] << amt;
      end else begin
         amt  = 7'(-s);
         v    = p >> amt;
         clip = |v[127:63];
         t    = v[63:0];
      end
      if (clip) t = POS_MAX;
      return {clip, t};
   endfunction

   pga_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .p (mul_p)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         P_IDLE:  if (start) state_in = P_DIFF;
         P_DIFF:  state_in = P_NORM;
         P_NORM:  state_in = (mx == '0) ? P_DONE : P_SQ;
         P_SQ:    if (mul_done && c_ff == 2'd2) state_in = P_SQRT;
         P_SQRT:  if (cnt_ff == SQRT_LAST) state_in = P_R3;
         P_R3:    if (mul_done) state_in = P_DIV;
         P_DIV:   if (cnt_ff == '0) state_in = P_TH;
         P_TH:    if (mul_done) state_in = P_PJ;
         P_PJ:    if (mul_done) state_in = P_PI;
         P_PI:    if (mul_done) state_in = P_SCALE;
         P_SCALE: state_in = (c_ff == 2'd2) ? P_DONE : P_TH;
         P_DONE:  state_in = P_IDLE;
         default: state_in = P_IDLE;
      endcase
   end

   // outputs and multiplier operands
   always_comb begin
      done      = (state_ff == P_DONE);
      mul_start = 1'b0;
      mul_a     = dn_ff[c_ff];
      mul_b     = dn_ff[c_ff];
      case (state_ff)
         P_SQ:    mul_start = !busy_ff;
         P_R3: begin
            mul_start = !busy_ff; mul_a = r2_ff[127:64]; mul_b = root_ff;
         end
         P_TH: begin
            mul_start = !busy_ff; mul_b = q_ff;
         end
         P_PJ: begin
            mul_start = !busy_ff; mul_a = th_ff; mul_b = head.mass;
         end
         P_PI: begin
            mul_start = !busy_ff; mul_a = th_ff; mul_b = pivot.mass;
         end
         default: mul_start = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      mag_in = mag_ff; dn_in = dn_ff; neg_in = neg_ff; e_in = e_ff;
      r2_in = r2_ff; sx_in = sx_ff; pj_in = pj_ff; pi_in = pi_ff;
      root_in = root_ff; r3h_in = r3h_ff; dr_in = dr_ff; q_in = q_ff; th_in = th_ff;
      rem_in = rem_ff; cnt_in = cnt_ff; c_in = c_ff; res_in = res_ff;
      busy_in = busy_ff;
      if (mul_start) busy_in = 1'b1;
      if (mul_done)  busy_in = 1'b0;

      mx = mag_ff[0];
      if (mag_ff[1] > mx) mx = mag_ff[1];
      if (mag_ff[2] > mx) mx = mag_ff[2];
      bl  = bitlen(mx);
      e_n = 7'd62 - bl;
      a = '0; b = '0; remv = '0; carry = 1'b0;
      rem_t = {rem_ff[64:0], sx_ff[127:126]};
      trial = {1'b0, root_ff, 2'b01};
      sh = $signed({e_ff[6], e_ff, 1'b0}) - 9'sd114;
      sj = scale_term(pj_ff, sh);
      si = scale_term(pi_ff, sh);

      case (state_ff)
         P_DIFF: begin
            for (int c = 0; c < 3; c++) begin
               a = (c == 0) ? pivot.px : (c == 1) ? pivot.py : pivot.pz;
               b = (c == 0) ? head.px  : (c == 1) ? head.py  : head.pz;
               if ((a ^ NEG_MIN) >= (b ^ NEG_MIN)) begin
                  mag_in[c] = a - b; neg_in[c] = 1'b0;
               end else begin
                  mag_in[c] = b - a; neg_in[c] = 1'b1;
               end
            end
         end
         P_NORM: begin
            e_in = e_n;
            for (int c = 0; c < 3; c++) begin
               if (!e_n[6]) dn_in[c] = mag_ff[c] << e_n[5:0];
               else         dn_in[c] = mag_ff[c] >> 2'(-e_n);
            end
            r2_in = '0;
            c_in  = '0;
            res_in.skip = (mx == '0);
            res_in.neg  = neg_ff;
         end
         P_SQ: begin
            if (mul_done) begin
               r2_in = r2_ff + mul_p;
               if (c_ff == 2'd2) begin
                  sx_in = r2_ff + mul_p; root_in = '0; rem_in = '0; cnt_in = '0;
               end else begin
                  c_in = c_ff + 2'd1;
               end
            end
         end
         P_SQRT: begin
            if (rem_t >= trial) begin
               rem_in = rem_t - trial; root_in = {root_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_t; root_in = {root_ff[62:0], 1'b0};
            end
            sx_in  = sx_ff << 2;
            cnt_in = cnt_ff + 7'd1;
         end
         P_R3: begin
            if (mul_done) begin
               r3h_in = mul_p[127:64]; dr_in = '0; q_in = '0; cnt_in = DIV_TOP;
            end
         end
         P_DIV: begin
            carry = dr_ff[63];
            remv  = {dr_ff[62:0], (cnt_ff == DIV_ONE)};
            if (carry || remv >= r3h_ff) begin
               dr_in = remv - r3h_ff; q_in = {q_ff[62:0], 1'b1};
            end else begin
               dr_in = remv; q_in = {q_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            c_in   = '0;
         end
         P_TH:  if (mul_done) th_in = mul_p[124:61];
         P_PJ:  if (mul_done) pj_in = mul_p;
         P_PI:  if (mul_done) pi_in = mul_p;
         P_SCALE: begin
            res_in.ti[c_ff] = sj[63:0]; res_in.ci[c_ff] = sj[64];
            res_in.tj[c_ff] = si[63:0]; res_in.cj[c_ff] = si[64];
            c_in = c_ff + 2'd1;
         end
         default: c_in = c_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         c_ff     <= '0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         c_ff     <= c_in;
      end
      mag_ff <= mag_in; dn_ff <= dn_in; neg_ff <= neg_in; e_ff <= e_in;
      r2_ff <= r2_in; sx_ff <= sx_in; pj_ff <= pj_in; pi_ff <= pi_in;
      root_ff <= root_in; r3h_ff <= r3h_in; dr_ff <= dr_in; q_ff <= q_in;
      th_ff <= th_in; rem_ff <= rem_in; res_ff <= res_in;
   end

   assign result = res_ff;
endmodule
`default_nettype wire

@@ sv/pga_checker.sv @@
// port-level checks for the gravity acceleration block, bound to the top level
// depends on pga_pkg and pairwise_gravity_acceleration_top_assert.svh
`default_nettype none
`include "pairwise_gravity_acceleration_top_assert.svh"
module pga_checker import pga_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             req_tlast,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);
   // loading and result phases never overlap
   `PGA_ASSERT_NOW(a_no_overlap, clock, reset, req_tready, !rsp_tvalid, "load and output overlap")
   // a stalled result holds
   `PGA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   // closing body starts the computation
   `PGA_ASSERT_NEXT(a_set_closes, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "load continued after last body")
   // final result returns to loading
   `PGA_ASSERT_NEXT(a_set_done, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, req_tready && !rsp_tvalid, "no return to loading")
endmodule

bind pairwise_gravity_acceleration_top pga_checker u_pga_checker (
   .clock (clock), .reset (reset),
   .req_tvalid (req_tvalid), .req_tready (req_tready), .req_tlast (req_tlast),
   .rsp_tvalid (rsp_tvalid), .rsp_tready (rsp_tready),
   .rsp_tdata (rsp_tdata), .rsp_tlast (rsp_tlast)
);
`default_nettype wire
